>>> sv/float_to_decimal_ascii_top_defines.svh
// Assertion macros for the float to decimal text block.
`ifndef FLOAT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define FLOAT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef SYNTH
`define FTDA_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftda check failed");
`define FTDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftda check failed");
`else
`define FTDA_ASSERT(lbl, ante, cons)
`define FTDA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/ftda_pkg.sv
// Shared types, constants and helpers of the float to decimal text block.
package ftda_pkg;

    localparam int MAX_FRAC_DIGITS   = 7;
    localparam int TEXT_BUFFER_CHARS = 15;

    localparam int ADDR_W = $clog2(TEXT_BUFFER_CHARS);
    localparam int CNT_W  = 4;
    localparam int INT_W  = 31;
    localparam int FRAC_W = 24;

    localparam int EXP_BIAS = 127;
    localparam logic [7:0] EXP_INT_ONLY = 8'(EXP_BIAS + 23);
    localparam logic [7:0] EXP_MAX_OK   = 8'(EXP_BIAS + 30);
    localparam logic [7:0] EXP_MIN_OK   = 8'(EXP_BIAS - 23);
    localparam logic [7:0] EXP_ONE      = 8'(EXP_BIAS);
    localparam logic [7:0] EXP_HALF     = 8'(EXP_BIAS - 1);

    // reciprocal of ten, exact for all 32-bit dividends with a 35-bit shift
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int DIV10_SHIFT = 35;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_TOO_SMALL = 2'd2
    } ftda_status_t;

    typedef struct packed {
        logic              go;
        logic [ADDR_W-1:0] len;
        ftda_status_t      status;
    } ftda_start_t;

    localparam logic [INT_W-1:0] POW10 [1:9] = '{
        31'd10, 31'd100, 31'd1000, 31'd10000, 31'd100000,
        31'd1000000, 31'd10000000, 31'd100000000, 31'd1000000000
    };

    // number of decimal digits of x, at least one
    function automatic logic [CNT_W-1:0] int_digits(input logic [INT_W-1:0] x);
        logic [CNT_W-1:0] n;
        n = CNT_W'(1);
        for (int k = 1; k <= 9; k++) begin
            if (x >= POW10[k])
                n = n + CNT_W'(1);
        end
        return n;
    endfunction

endpackage

>>> sv/ftda_in_if.sv
// Input channel: one float bit pattern per word.
interface ftda_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

>>> sv/ftda_out_if.sv
// Output channel: one text character per word.
interface ftda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output char_code, output status, output last, input ready);
    modport sink   (input valid, input char_code, input status, input last, output ready);
endinterface

>>> sv/ftda_digit_unit.sv
// Shared digit unit: divide by ten for integer digits, times ten for fraction digits.
module ftda_digit_unit
    import ftda_pkg::*;
(
    input  logic              clk,
    input  logic              div_load,
    input  logic [INT_W-1:0]  x,
    output logic [INT_W-1:0]  q,
    output logic [3:0]        rem_digit,
    input  logic [FRAC_W-1:0] frac_in,
    output logic [3:0]        frac_digit,
    output logic [FRAC_W-1:0] frac_out
);

    logic [INT_W+31:0]  prod;
    logic [INT_W-1:0]   q_reg;
    logic [INT_W-1:0]   ten_q;
    logic [INT_W-1:0]   rem_full;
    logic [FRAC_W+3:0]  frac_ext;
    logic [FRAC_W+3:0]  frac_x10;

    assign prod = (INT_W+32)'(x) * (INT_W+32)'(DIV10_MAGIC);

    always_ff @(posedge clk)
    begin
        if (div_load)
            q_reg <= INT_W'(prod >> DIV10_SHIFT);
    end

    assign q         = q_reg;
    assign ten_q     = (q_reg << 3) + (q_reg << 1);
    assign rem_full  = x - ten_q;
    assign rem_digit = rem_full[3:0];

    // fraction times ten; the carry above bit 23 is the digit
    assign frac_ext   = (FRAC_W+4)'(frac_in);
    assign frac_x10   = (frac_ext << 3) + (frac_ext << 1);
    assign frac_digit = frac_x10[FRAC_W+3:FRAC_W];
    assign frac_out   = frac_x10[FRAC_W-1:0];

endmodule

>>> sv/ftda_text_buf.sv
// Text buffer and output register; sends one finished text a character per word.
module ftda_text_buf
    import ftda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_char,
    input  ftda_start_t       start,
    output logic              busy,
    ftda_out_if.source        text
);

    logic [7:0]        mem [TEXT_BUFFER_CHARS];
    logic              busy_reg;
    logic [ADDR_W-1:0] rd_reg;
    logic [ADDR_W-1:0] len_reg;
    ftda_status_t      st_reg;
    logic              valid_reg;
    logic [7:0]        char_reg;
    ftda_status_t      status_reg;
    logic              last_reg;
    logic              load;
    logic              at_end;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_char;
    end

    assign load   = busy_reg && (!valid_reg || text.ready);
    assign at_end = (rd_reg == len_reg - ADDR_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            rd_reg    <= '0;
        end
        else
        begin
            if (start.go)
            begin
                busy_reg <= 1'b1;
                rd_reg   <= '0;
            end
            else if (load)
            begin
                rd_reg <= rd_reg + ADDR_W'(1);
                if (at_end)
                    busy_reg <= 1'b0;
            end

            if (load)
                valid_reg <= 1'b1;
            else if (text.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start.go)
        begin
            len_reg <= start.len;
            st_reg  <= start.status;
        end
        if (load)
        begin
            char_reg   <= mem[rd_reg];
            status_reg <= st_reg;
            last_reg   <= at_end;
        end
    end

    assign busy           = busy_reg;
    assign text.valid     = valid_reg;
    assign text.char_code = char_reg;
    assign text.status    = status_reg;
    assign text.last      = last_reg;

endmodule

>>> sv/float_to_decimal_ascii_top.sv
// Top level: float bit pattern in, decimal text out one character per word.
//
//   channel  dir  payload                      word
//   value    in   float_bits[31:0]             one single-precision pattern
//   text     out  char_code[7:0], status, last one character or one error
//
// Per value: accept, setup, a divide and a write step per integer digit (1..10),
// the '.', a step per fraction digit (1..7), digits all through the one digit
// unit; the buffer then sends one character per cycle unless text stalls.
// Error values take accept, setup and one output word.
// The next value is taken once the final character sits in the output register.
// rst_n clears the sequencer and the output valid; a stall on text holds the word.
`include "float_to_decimal_ascii_top_defines.svh"

module float_to_decimal_ascii_top
    import ftda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ftda_in_if.sink    value,
    ftda_out_if.source text
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_DIV   = 6'b000100,
        S_DIGIT = 6'b001000,
        S_DOT   = 6'b010000,
        S_FRAC  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic              sign_reg, sign_next;
    ftda_status_t      err_reg, err_next;
    logic [INT_W-1:0]  work_reg, work_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [ADDR_W-1:0] wptr_reg, wptr_next;
    logic [ADDR_W-1:0] dot_reg, dot_next;
    logic [ADDR_W-1:0] keep_reg, keep_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [7:0]        e8;
    logic [FRAC_W-1:0] mant;
    logic              zero_in;
    ftda_status_t      status_in;
    logic [INT_W-1:0]  ipart_in;
    logic [FRAC_W-1:0] fpart_in;
    logic [7:0]        sh_up;
    logic [7:0]        sh_int;
    logic [7:0]        sh_frac;
    logic [7:0]        sh_low;

    logic              div_load;
    logic [INT_W-1:0]  q;
    logic [3:0]        rem_digit;
    logic [3:0]        frac_digit;
    logic [FRAC_W-1:0] frac_out;
    logic [CNT_W-1:0]  nd;
    logic [ADDR_W:0]   room_full;
    logic [CNT_W-1:0]  room;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_char;
    ftda_start_t       start;
    logic              busy;

    // classify and align the incoming value
    assign e8      = value.float_bits[30:23];
    assign mant    = {1'b1, value.float_bits[22:0]};
    assign zero_in = (value.float_bits[30:0] == 31'd0);
    assign sh_up   = e8 - EXP_INT_ONLY;
    assign sh_int  = EXP_INT_ONLY - e8;
    assign sh_frac = e8 - EXP_HALF;
    assign sh_low  = EXP_HALF - e8;

    always_comb
    begin
        status_in = ST_OK;
        ipart_in  = '0;
        fpart_in  = '0;
        if (!zero_in)
        begin
            if (e8 > EXP_MAX_OK)
                status_in = ST_TOO_LARGE;
            else if (e8 < EXP_MIN_OK)
                status_in = ST_TOO_SMALL;

            if (e8 >= EXP_INT_ONLY)
                ipart_in = INT_W'(mant) << sh_up[2:0];
            else if (e8 >= EXP_ONE)
            begin
                ipart_in = INT_W'(mant >> sh_int[4:0]);
                fpart_in = mant << sh_frac[4:0];
            end
            else
                fpart_in = mant >> sh_low[4:0];
        end
    end

    ftda_digit_unit u_digit (
        .clk        (clk),
        .div_load   (div_load),
        .x          (work_reg),
        .q          (q),
        .rem_digit  (rem_digit),
        .frac_in    (frac_reg),
        .frac_digit (frac_digit),
        .frac_out   (frac_out)
    );

    assign nd        = int_digits(work_reg);
    assign room_full = (ADDR_W+1)'(TEXT_BUFFER_CHARS - 2) - {1'b0, dot_reg};

    always_comb
    begin
        if ({1'b0, dot_reg} >= (ADDR_W+1)'(TEXT_BUFFER_CHARS - 2))
            room = '0;
        else if (room_full > (ADDR_W+1)'(MAX_FRAC_DIGITS))
            room = CNT_W'(MAX_FRAC_DIGITS);
        else
            room = room_full[CNT_W-1:0];
    end

    assign value.ready = (state_reg == S_IDLE) && !busy;

    always_comb
    begin
        state_next = state_reg;
        sign_next  = sign_reg;
        err_next   = err_reg;
        work_next  = work_reg;
        frac_next  = frac_reg;
        wptr_next  = wptr_reg;
        dot_next   = dot_reg;
        keep_next  = keep_reg;
        cnt_next   = cnt_reg;
        div_load   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = wptr_reg;
        wr_char    = CH_NUL;
        start      = '{go: 1'b0, len: '0, status: ST_OK};

        case (state_reg)
            S_IDLE:
            begin
                if (value.valid && value.ready)
                begin
                    sign_next  = value.float_bits[31] & !zero_in;
                    err_next   = status_in;
                    work_next  = ipart_in;
                    frac_next  = fpart_in;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (err_reg != ST_OK)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_char    = CH_NUL;
                    start      = '{go: 1'b1, len: ADDR_W'(1), status: err_reg};
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_en      = sign_reg;
                    wr_addr    = '0;
                    wr_char    = CH_MINUS;
                    dot_next   = ADDR_W'(sign_reg) + ADDR_W'(nd);
                    wptr_next  = ADDR_W'(sign_reg) + ADDR_W'(nd) - ADDR_W'(1);
                    cnt_next   = nd;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                div_load   = 1'b1;
                state_next = S_DIGIT;
            end
            S_DIGIT:
            begin
                // integer digits come least significant first, written right to left
                wr_en      = 1'b1;
                wr_char    = CH_ZERO + {4'd0, rem_digit};
                wptr_next  = wptr_reg - ADDR_W'(1);
                work_next  = q;
                cnt_next   = cnt_reg - CNT_W'(1);
                state_next = (cnt_reg == CNT_W'(1)) ? S_DOT : S_DIV;
            end
            S_DOT:
            begin
                wr_en     = 1'b1;
                wr_addr   = dot_reg;
                wr_char   = CH_DOT;
                wptr_next = dot_reg + ADDR_W'(1);
                keep_next = dot_reg + ADDR_W'(2);
                // a zero fraction still prints one '0'
                cnt_next  = (frac_reg == '0) ? CNT_W'(1) : room;
                if (frac_reg != '0 && room == '0)
                begin
                    start      = '{go: 1'b1, len: dot_reg + ADDR_W'(1), status: ST_OK};
                    state_next = S_IDLE;
                end
                else
                    state_next = S_FRAC;
            end
            S_FRAC:
            begin
                wr_en     = 1'b1;
                wr_char   = CH_ZERO + {4'd0, frac_digit};
                frac_next = frac_out;
                wptr_next = wptr_reg + ADDR_W'(1);
                cnt_next  = cnt_reg - CNT_W'(1);
                // keep marks the end of text after trailing zeros are dropped
                if (frac_digit != 4'd0)
                    keep_next = wptr_reg + ADDR_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    start      = '{go: 1'b1,
                                   len: (frac_digit != 4'd0) ? wptr_reg + ADDR_W'(1) : keep_reg,
                                   status: ST_OK};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        err_reg  <= err_next;
        work_reg <= work_next;
        frac_reg <= frac_next;
        wptr_reg <= wptr_next;
        dot_reg  <= dot_next;
        keep_reg <= keep_next;
        cnt_reg  <= cnt_next;
    end

    ftda_text_buf u_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_char (wr_char),
        .start   (start),
        .busy    (busy),
        .text    (text)
    );

    `FTDA_ASSERT(a_start_len, start.go, start.len != '0)
    `FTDA_ASSERT(a_err_word, text.valid && text.status != ST_OK, text.last && text.char_code == CH_NUL)
    `FTDA_ASSERT_NEXT(a_accept_setup, value.valid && value.ready, state_reg == S_SETUP && !busy)
    `FTDA_ASSERT(a_frac_cnt, state_reg == S_FRAC, cnt_reg != '0)

endmodule

>>> sim/float_to_decimal_ascii_top_tb.sv
// Testbench: directed table of values, then random values checked against a predictor.
module float_to_decimal_ascii_top_tb;
    import ftda_pkg::*;

    localparam int N_DIRECTED        = 25;
    localparam int N_RANDOM_PHASE0   = 70;
    localparam int N_RANDOM_PHASE1   = 80;
    localparam int N_RANDOM_PHASE2   = 86;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES      = 64;
    localparam int CYCLE_LIMIT       = 200000;
    localparam logic [31:0] FRAC_MASK  = 32'h00FF_FFFF;
    localparam logic [31:0] HIDDEN_ONE = 32'h0080_0000;

    typedef struct packed {
        logic [7:0]   char_code;
        ftda_status_t status;
        logic         last;
    } text_word_t;

    // text empty and status ok: row goes through the predictor
    typedef struct {
        logic [31:0]  bits;
        ftda_status_t status;
        string        text;
    } directed_row_t;

    logic clk;
    logic rst_n;

    ftda_in_if  value_if ();
    ftda_out_if text_if ();

    float_to_decimal_ascii_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .value (value_if),
        .text  (text_if)
    );

    text_word_t pending_chars[$];
    int         sender_idle_pct;
    int         recv_idle_pct;
    bit         hold_req;
    bit         hold_done;
    int         mismatches;
    int         values_sent;
    int         chars_checked;
    int         too_large_seen;
    int         too_small_seen;
    int         cycle_count;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, ST_OK,        "0.0"},
        '{32'h8000_0000, ST_OK,        "0.0"},
        '{32'h3F80_0000, ST_OK,        "1.0"},
        '{32'hBF80_0000, ST_OK,        "-1.0"},
        '{32'h3F00_0000, ST_OK,        "0.5"},
        '{32'h3E80_0000, ST_OK,        "0.25"},
        '{32'h7F80_0000, ST_TOO_LARGE, ""},
        '{32'hFF80_0000, ST_TOO_LARGE, ""},
        '{32'h7FC0_0000, ST_TOO_LARGE, ""},
        '{32'h4F00_0000, ST_TOO_LARGE, ""},
        '{32'h0000_0001, ST_TOO_SMALL, ""},
        '{32'h807F_FFFF, ST_TOO_SMALL, ""},
        '{32'h3380_0000, ST_TOO_SMALL, ""},
        '{32'h3400_0000, ST_OK,        ""},
        '{32'h4EFF_FFFF, ST_OK,        "2147483520.0"},
        '{32'hCEFF_FFFF, ST_OK,        "-2147483520.0"},
        '{32'h4B00_0000, ST_OK,        "8388608.0"},
        '{32'h461C_4000, ST_OK,        "10000.0"},
        '{32'h4CBE_BC20, ST_OK,        "100000000.0"},
        '{32'h3DCC_CCCD, ST_OK,        ""},
        '{32'h4049_0FDB, ST_OK,        ""},
        '{32'hC2F6_E979, ST_OK,        ""},
        '{32'h3F7F_FFFF, ST_OK,        ""},
        '{32'hC996_B43C, ST_OK,        ""},
        '{32'hB4FF_FFFF, ST_OK,        ""}
    };

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_chars.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_error(input ftda_status_t st);
        pending_chars.push_back('{CH_NUL, st, 1'b1});
    endtask

    // decimal text of one single-precision pattern, truncated fraction digits, or its error word
    task automatic predict_text(input logic [31:0] bits);
        logic [7:0]  chars[$];
        logic [7:0]  rev_digits[$];
        logic [31:0] mant;
        logic [31:0] ipart;
        logic [31:0] fpart;
        int          e;
        int          room;
        if (bits[30:0] == 31'd0)
        begin
            chars = '{CH_ZERO, CH_DOT, CH_ZERO};
        end
        else
        begin
            e = int'(bits[30:23]) - EXP_BIAS;
            if (e >= 31)
            begin
                push_error(ST_TOO_LARGE);
                return;
            end
            if (e < -23)
            begin
                push_error(ST_TOO_SMALL);
                return;
            end
            mant  = (bits & FRAC_MASK) | HIDDEN_ONE;
            ipart = '0;
            fpart = '0;
            if (e >= 23)
            begin
                ipart = mant << (e - 23);
            end
            else if (e >= 0)
            begin
                ipart = mant >> (23 - e);
                fpart = (mant << (e + 1)) & FRAC_MASK;
            end
            else
            begin
                fpart = mant >> (-(e + 1));
            end
            if (bits[31])
                chars.push_back(CH_MINUS);
            if (ipart == 0)
            begin
                chars.push_back(CH_ZERO);
            end
            else
            begin
                while (ipart != 0)
                begin
                    rev_digits.push_back(CH_ZERO + 8'(ipart % 10));
                    ipart = ipart / 10;
                end
                while (rev_digits.size() > 0)
                    chars.push_back(rev_digits.pop_back());
            end
            chars.push_back(CH_DOT);
            if (fpart == 0)
            begin
                chars.push_back(CH_ZERO);
            end
            else
            begin
                room = TEXT_BUFFER_CHARS - chars.size() - 1;
                if (room > MAX_FRAC_DIGITS)
                    room = MAX_FRAC_DIGITS;
                if (room < 0)
                    room = 0;
                repeat (room)
                begin
                    fpart = fpart * 10;
                    chars.push_back(CH_ZERO + 8'(fpart >> 24));
                    fpart = fpart & FRAC_MASK;
                end
                // trailing zeros go, one digit after the dot stays
                while (chars.size() >= 2 && chars[$] == CH_ZERO && chars[$-1] != CH_DOT)
                    void'(chars.pop_back());
            end
        end
        foreach (chars[i])
            pending_chars.push_back('{chars[i], ST_OK, (i == chars.size() - 1)});
    endtask

    function automatic logic [31:0] random_float_bits();
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] frac;
        int          pick;
        sgn  = 1'($urandom_range(1));
        frac = 23'($urandom);
        pick = $urandom_range(99);
        if (pick < 6)
            return {sgn, 31'd0};
        if (pick < 30 && pick >= 22)
            return $urandom;
        if (pick < 14)
            ex = 8'($urandom_range(255, 158));
        else if (pick < 22)
            ex = 8'($urandom_range(103, 0));
        else if (pick < 45)
            ex = 8'($urandom_range(126, 104));
        else
            ex = 8'($urandom_range(157, 127));
        // short fractions give texts with trailing zeros to trim
        if ($urandom_range(2) == 0)
            frac = frac & (23'h7F_FFFF << $urandom_range(22));
        return {sgn, ex, frac};
    endfunction

    task automatic send_value(input logic [31:0] bits);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            value_if.valid      <= 1'b0;
            value_if.float_bits <= $urandom;
            @(negedge clk);
        end
        value_if.valid      <= 1'b1;
        value_if.float_bits <= bits;
        do
            @(posedge clk);
        while (!value_if.ready);
        values_sent++;
    endtask

    // receiver: random ready, one long hold-off on request
    initial
    begin
        text_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                text_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            text_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        text_word_t want;
        if (rst_n && text_if.valid && text_if.ready)
        begin
            if (text_if.status == ST_TOO_LARGE)
                too_large_seen++;
            if (text_if.status == ST_TOO_SMALL)
                too_small_seen++;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected word: char_code %h status %0d last %b",
                       text_if.char_code, text_if.status, text_if.last);
                mismatches++;
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (text_if.char_code !== want.char_code)
                begin
                    $error("char_code: expected %h, got %h", want.char_code, text_if.char_code);
                    mismatches++;
                end
                if (text_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, text_if.status);
                    mismatches++;
                end
                if (text_if.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, text_if.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        directed_row_t row;
        logic [31:0]   bits;
        rst_n               = 1'b0;
        value_if.valid      = 1'b0;
        value_if.float_bits = '0;
        hold_req            = 1'b0;
        hold_done           = 1'b0;
        mismatches          = 0;
        values_sent         = 0;
        chars_checked       = 0;
        too_large_seen      = 0;
        too_small_seen      = 0;
        cycle_count         = 0;
        sender_idle_pct     = 16;
        recv_idle_pct       = 61;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            send_value(row.bits);
            if (row.status != ST_OK)
            begin
                push_error(row.status);
            end
            else if (row.text.len() == 0)
            begin
                predict_text(row.bits);
            end
            else
            begin
                for (int k = 0; k < row.text.len(); k++)
                    pending_chars.push_back('{8'(row.text[k]), ST_OK,
                                            (k == row.text.len() - 1)});
            end
        end
        for (int i = 0; i < N_RANDOM_PHASE0; i++)
        begin
            bits = random_float_bits();
            send_value(bits);
            predict_text(bits);
        end

        // sender pause: let the text side run dry
        @(negedge clk);
        value_if.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);

        sender_idle_pct = 61;
        recv_idle_pct   = 16;
        for (int i = 0; i < N_RANDOM_PHASE1; i++)
        begin
            bits = random_float_bits();
            send_value(bits);
            predict_text(bits);
        end

        // no idling; the receiver blocks for a while so the input backs up
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        hold_req        = 1'b1;
        for (int i = 0; i < N_RANDOM_PHASE2; i++)
        begin
            bits = random_float_bits();
            send_value(bits);
            predict_text(bits);
        end

        @(negedge clk);
        value_if.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d values in (%0d from the table), %0d text words checked",
                 values_sent, N_DIRECTED, chars_checked);
        $display("%0d too-large and %0d too-small errors seen, %0d mismatches",
                 too_large_seen, too_small_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
